// ===== hw/rtl/jls_pkg.sv =====
`default_nettype none

package jls_pkg;

    // item command codes
    localparam logic [1:0] CMD_MATRIX = 2'd0;
    localparam logic [1:0] CMD_RHS    = 2'd1;
    localparam logic [1:0] CMD_SOLVE  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SIZE   = 2'd0;
    localparam logic [1:0] CFG_TOL    = 2'd1;
    localparam logic [1:0] CFG_MAXIT  = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SWEEP_START,
        ST_ROW_START,
        ST_ROW_ISSUE,
        ST_ROW_DRAIN,
        ST_ROW_NUM,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_ROW_WB,
        ST_SWEEP_WAIT,
        ST_SWEEP_CHK,
        ST_RES_START,
        ST_RES_ROW,
        ST_RES_ISSUE,
        ST_RES_DRAIN,
        ST_RES_SUB,
        ST_RES_MAG,
        ST_RES_SQ,
        ST_RES_ADD,
        ST_SQRT_START,
        ST_SQRT_WAIT,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

    // controller -> datapath strobes
    typedef struct packed {
        logic x_clear;
        logic mac_issue;
        logic mac_all;
        logic acc_clear;
        logic num_load;
        logic div_start;
        logic row_wb;
        logic maxd_clear;
        logic bank_flip;
        logic res_clear;
        logic res_sub;
        logic res_mag;
        logic res_sq;
        logic res_add;
        logic sqrt_start;
        logic out_load;
        logic out_last;
        logic conv;
    } ctl_t;

    // datapath -> controller status
    typedef struct packed {
        logic mac_busy;
        logic diag_zero;
        logic div_busy;
        logic chk_busy;
        logic lt_tol;
        logic sqrt_busy;
        logic out_busy;
    } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/jls_ram.sv =====
`default_nettype none

module jls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/jls_div.sv =====
`default_nettype none

// 64 / 32 signed divide, one quotient bit per cycle, truncating,
// result saturated to signed 32 bits.
module jls_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [31:0] den,
    output logic               busy,
    output logic signed [31:0] quot
);

    localparam int NB   = 64;
    localparam int CNTW = $clog2(NB + 1);

    logic            busy_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [63:0]     q_reg;
    logic [31:0]     rem_reg;
    logic [31:0]     d_reg;
    logic            neg_reg;
    logic [32:0]     sh;
    logic            ge;

    assign sh   = {rem_reg, q_reg[63]};
    assign ge   = sh >= {1'b0, d_reg};
    assign busy = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNTW'(NB);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - CNTW'(1);
            busy_reg <= cnt_reg != CNTW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num[63] ? 64'd0 - num : num;
            d_reg   <= den[31] ? 32'd0 - den : den;
            neg_reg <= num[63] ^ den[31];
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 32'(sh - {1'b0, d_reg}) : sh[31:0];
            q_reg   <= {q_reg[62:0], ge};
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            quot = (q_reg > 64'h8000_0000) ? 32'sh8000_0000 : 32'(32'd0 - q_reg[31:0]);
        end
        else
        begin
            quot = (q_reg > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q_reg[31:0];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/jls_sqrt.sv =====
`default_nettype none

// Floor square root of a 64-bit value, two radicand bits per cycle.
module jls_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] value,
    output logic        busy,
    output logic [31:0] root
);

    localparam int NS   = 32;
    localparam int CNTW = $clog2(NS + 1);

    logic            busy_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [63:0]     v_reg;
    logic [31:0]     root_reg;
    logic [33:0]     rem_reg;
    logic [35:0]     sh;
    logic [35:0]     trial;
    logic            ge;

    assign sh    = {rem_reg, v_reg[63:62]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign ge    = sh >= trial;
    assign busy  = busy_reg;
    assign root  = root_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNTW'(NS);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - CNTW'(1);
            busy_reg <= cnt_reg != CNTW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= value;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? 34'(sh - trial) : sh[33:0];
            root_reg <= {root_reg[30:0], ge};
            v_reg    <= {v_reg[61:0], 2'b00};
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/jls_datapath.sv =====
`default_nettype none

module jls_datapath #(
    parameter int MAX_SIZE  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  jls_pkg::ctl_t               ctl,
    input  logic [$clog2(MAX_SIZE)-1:0] i_idx,
    input  logic [$clog2(MAX_SIZE)-1:0] j_idx,
    input  logic                        load_en,
    input  logic [1:0]                  cmd,
    input  logic [3:0]                  row,
    input  logic [3:0]                  col,
    input  logic signed [31:0]          value,
    input  logic [30:0]                 tolerance,
    input  logic [15:0]                 sweeps,
    output jls_pkg::stat_t              stat,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [3:0]                  index,
    output logic signed [31:0]          solution,
    output logic [15:0]                 iterations,
    output logic                        converged,
    output logic [31:0]                 residual,
    output logic                        last
);

    import jls_pkg::*;

    localparam int IW = $clog2(MAX_SIZE);
    localparam int AW = $clog2(MAX_SIZE * MAX_SIZE);
    localparam logic signed [63:0] S64_MIN = {1'b1, 63'd0};
    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};

    function automatic logic signed [63:0] sat64(input logic [64:0] s);
        if (s[64] != s[63])
        begin
            sat64 = s[64] ? S64_MIN : S64_MAX;
        end
        else
        begin
            sat64 = s[63:0];
        end
    endfunction

    // stores
    logic               a_we, b_we, x0_we, x1_we;
    logic [AW-1:0]      a_waddr, a_raddr;
    logic [IW-1:0]      x_raddr;
    logic signed [31:0] a_rd, b_rd;
    logic [31:0]        x0_rd, x1_rd, x_wdata;
    logic signed [31:0] x_rd;
    logic               bank_reg;

    // multiply-accumulate pipeline
    logic               v1_reg, v2_reg, d1_reg, incl1_reg, incl2_reg;
    logic signed [63:0] prod_reg, acc_reg;
    logic signed [31:0] diag_reg, xi_reg;

    // row update
    logic signed [63:0] rw;
    logic signed [63:0] num_reg;
    logic signed [31:0] quot;
    logic signed [31:0] next_val;
    logic               div_busy;
    logic               dv1_reg, dv2_reg;
    logic [32:0]        ds_reg, dm_reg, maxd_reg;

    // residual
    logic signed [63:0] e_reg;
    logic [63:0]        e_mag, r_full;
    logic [31:0]        r_reg;
    logic [63:0]        sq_reg, rsq_reg;
    logic [64:0]        rsq_sum;
    logic               sat_reg;
    logic               sqrt_busy;
    logic [31:0]        root;

    logic               result_valid_reg;

    assign a_we    = load_en && (cmd == CMD_MATRIX)
                     && (int'(row) < MAX_SIZE) && (int'(col) < MAX_SIZE);
    assign b_we    = load_en && (cmd == CMD_RHS) && (int'(row) < MAX_SIZE);
    assign a_waddr = AW'(int'(row) * MAX_SIZE + int'(col));
    assign a_raddr = AW'(int'(i_idx) * MAX_SIZE + int'(j_idx));
    assign x_raddr = ctl.mac_issue ? j_idx : i_idx;
    assign x_rd    = bank_reg ? x1_rd : x0_rd;

    assign next_val = stat.diag_zero ? xi_reg : quot;
    assign x_wdata  = ctl.x_clear ? 32'd0 : next_val;
    assign x0_we    = (ctl.x_clear && !bank_reg) || (ctl.row_wb && bank_reg);
    assign x1_we    = (ctl.x_clear && bank_reg) || (ctl.row_wb && !bank_reg);

    jls_ram #(.WIDTH(32), .DEPTH(MAX_SIZE * MAX_SIZE)) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (value),
        .raddr (a_raddr),
        .rdata (a_rd)
    );

    jls_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (IW'(row)),
        .wdata (value),
        .raddr (i_idx),
        .rdata (b_rd)
    );

    jls_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_x0_ram (
        .clk   (clk),
        .we    (x0_we),
        .waddr (i_idx),
        .wdata (x_wdata),
        .raddr (x_raddr),
        .rdata (x0_rd)
    );

    jls_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_x1_ram (
        .clk   (clk),
        .we    (x1_we),
        .waddr (i_idx),
        .wdata (x_wdata),
        .raddr (x_raddr),
        .rdata (x1_rd)
    );

    // b in the product scale
    assign rw = 64'(b_rd) <<< FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg         <= 1'b0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            dv1_reg          <= 1'b0;
            dv2_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.bank_flip)
            begin
                bank_reg <= !bank_reg;
            end
            v1_reg  <= ctl.mac_issue;
            v2_reg  <= v1_reg;
            dv1_reg <= ctl.row_wb && !stat.diag_zero;
            dv2_reg <= dv1_reg;
            if (ctl.out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d1_reg    <= j_idx == i_idx;
        incl1_reg <= ctl.mac_all || (j_idx != i_idx);
        incl2_reg <= incl1_reg;
        prod_reg  <= a_rd * x_rd;
        if (v1_reg && d1_reg)
        begin
            diag_reg <= a_rd;
            xi_reg   <= x_rd;
        end
        if (ctl.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg && incl2_reg)
        begin
            acc_reg <= sat64({acc_reg[63], acc_reg} + {prod_reg[63], prod_reg});
        end

        // b - sigma, with the most negative sigma negated to the largest value
        if (ctl.num_load)
        begin
            num_reg <= sat64({rw[63], rw} + {~acc_reg[63], ~acc_reg}
                             + {64'd0, acc_reg != S64_MIN});
        end

        if (ctl.row_wb)
        begin
            ds_reg <= {quot[31], quot} - {xi_reg[31], xi_reg};
        end
        dm_reg <= ds_reg[32] ? 33'd0 - ds_reg : ds_reg;
        if (ctl.maxd_clear)
        begin
            maxd_reg <= '0;
        end
        else if (dv2_reg && (dm_reg > maxd_reg))
        begin
            maxd_reg <= dm_reg;
        end

        if (ctl.res_sub)
        begin
            e_reg <= sat64({acc_reg[63], acc_reg} - {rw[63], rw});
        end
        if (ctl.res_mag)
        begin
            r_reg <= r_full[31:0];
        end
        if (ctl.res_sq)
        begin
            sq_reg <= r_reg * r_reg;
        end
        if (ctl.res_clear)
        begin
            rsq_reg <= '0;
            sat_reg <= 1'b0;
        end
        else
        begin
            if (ctl.res_mag && (r_full[63:32] != 32'd0))
            begin
                sat_reg <= 1'b1;
            end
            if (ctl.res_add)
            begin
                rsq_reg <= rsq_sum[63:0];
                if (rsq_sum[64])
                begin
                    sat_reg <= 1'b1;
                end
            end
        end

        if (ctl.out_load)
        begin
            index      <= 4'(i_idx);
            solution   <= x_rd;
            iterations <= sweeps;
            converged  <= ctl.conv;
            residual   <= sat_reg ? 32'hFFFF_FFFF : root;
            last       <= ctl.out_last;
        end
    end

    assign e_mag   = e_reg[63] ? 64'd0 - e_reg : e_reg;
    assign r_full  = e_mag >> FRAC_BITS;
    assign rsq_sum = {1'b0, rsq_reg} + {1'b0, sq_reg};

    jls_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.div_start),
        .num   (num_reg),
        .den   (diag_reg),
        .busy  (div_busy),
        .quot  (quot)
    );

    jls_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ctl.sqrt_start),
        .value (rsq_reg),
        .busy  (sqrt_busy),
        .root  (root)
    );

    assign result_valid = result_valid_reg;

    always_comb
    begin
        stat.mac_busy  = v1_reg || v2_reg;
        stat.diag_zero = diag_reg == 32'sd0;
        stat.div_busy  = div_busy;
        stat.chk_busy  = dv1_reg || dv2_reg;
        stat.lt_tol    = maxd_reg < {2'b00, tolerance};
        stat.sqrt_busy = sqrt_busy;
        stat.out_busy  = result_valid_reg;
    end

    a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(div_busy && sqrt_busy))
        else $error("divider and square root unit busy together");

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(ctl.out_load))
        else $error("result valid without a load strobe");

endmodule

`default_nettype wire

// ===== hw/rtl/jls_ctrl.sv =====
`default_nettype none

module jls_ctrl #(
    parameter int MAX_SIZE = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [1:0]                  item_cmd,
    input  logic [4:0]                  size_in_use,
    input  logic [15:0]                 max_iterations,
    input  jls_pkg::stat_t              stat,
    output jls_pkg::ctl_t               ctl,
    output logic [$clog2(MAX_SIZE)-1:0] i_idx,
    output logic [$clog2(MAX_SIZE)-1:0] j_idx,
    output logic [15:0]                 sweeps,
    output logic                        item_stall
);

    import jls_pkg::*;

    localparam int IW = $clog2(MAX_SIZE);
    localparam int CW = $clog2(MAX_SIZE + 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, n_w;
    logic [15:0]   sweeps_reg, sweeps_next;
    logic          conv_reg, conv_next;
    logic          last_i, last_j, solve_go, stop_sweeps;

    assign n_w = (int'(size_in_use) > MAX_SIZE) ? CW'(MAX_SIZE) : CW'(size_in_use);
    assign last_i   = i_reg == n_w - CW'(1);
    assign last_j   = j_reg == n_w - CW'(1);
    assign solve_go = accept && (item_cmd == CMD_SOLVE) && (n_w != '0);
    assign stop_sweeps = stat.lt_tol
                         || (({1'b0, sweeps_reg} + 17'd1) >= {1'b0, max_iterations});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            sweeps_reg <= '0;
            conv_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            sweeps_reg <= sweeps_next;
            conv_reg   <= conv_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:        if (solve_go) state_next = ST_CLEAR;
            ST_CLEAR:
            begin
                if (last_i)
                begin
                    state_next = (max_iterations == 16'd0) ? ST_RES_START : ST_SWEEP_START;
                end
            end
            ST_SWEEP_START: state_next = ST_ROW_START;
            ST_ROW_START:   state_next = ST_ROW_ISSUE;
            ST_ROW_ISSUE:   if (last_j) state_next = ST_ROW_DRAIN;
            ST_ROW_DRAIN:
            begin
                if (!stat.mac_busy)
                begin
                    state_next = stat.diag_zero ? ST_ROW_WB : ST_ROW_NUM;
                end
            end
            ST_ROW_NUM:     state_next = ST_DIV_START;
            ST_DIV_START:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:    if (!stat.div_busy) state_next = ST_ROW_WB;
            ST_ROW_WB:      state_next = last_i ? ST_SWEEP_WAIT : ST_ROW_START;
            ST_SWEEP_WAIT:  if (!stat.chk_busy) state_next = ST_SWEEP_CHK;
            ST_SWEEP_CHK:   state_next = stop_sweeps ? ST_RES_START : ST_SWEEP_START;
            ST_RES_START:   state_next = ST_RES_ROW;
            ST_RES_ROW:     state_next = ST_RES_ISSUE;
            ST_RES_ISSUE:   if (last_j) state_next = ST_RES_DRAIN;
            ST_RES_DRAIN:   if (!stat.mac_busy) state_next = ST_RES_SUB;
            ST_RES_SUB:     state_next = ST_RES_MAG;
            ST_RES_MAG:     state_next = ST_RES_SQ;
            ST_RES_SQ:      state_next = ST_RES_ADD;
            ST_RES_ADD:     state_next = last_i ? ST_SQRT_START : ST_RES_ROW;
            ST_SQRT_START:  state_next = ST_SQRT_WAIT;
            ST_SQRT_WAIT:   if (!stat.sqrt_busy) state_next = ST_OUT_RD;
            ST_OUT_RD:      state_next = ST_OUT_LD;
            ST_OUT_LD:      state_next = ST_OUT_WAIT;
            ST_OUT_WAIT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = last_i ? ST_IDLE : ST_OUT_RD;
                end
            end
            default:        state_next = ST_IDLE;
        endcase
    end

    // counters
    always_comb
    begin
        i_next      = i_reg;
        j_next      = j_reg;
        sweeps_next = sweeps_reg;
        conv_next   = conv_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (solve_go)
                begin
                    i_next      = '0;
                    sweeps_next = '0;
                    conv_next   = 1'b0;
                end
            end
            ST_CLEAR:     i_next = last_i ? '0 : i_reg + CW'(1);
            ST_ROW_START, ST_RES_ROW: j_next = '0;
            ST_ROW_ISSUE, ST_RES_ISSUE: j_next = j_reg + CW'(1);
            ST_ROW_WB:    i_next = last_i ? '0 : i_reg + CW'(1);
            ST_SWEEP_CHK:
            begin
                i_next      = '0;
                sweeps_next = sweeps_reg + 16'd1;
                conv_next   = stat.lt_tol;
            end
            ST_RES_START: i_next = '0;
            ST_RES_ADD:   i_next = last_i ? '0 : i_reg + CW'(1);
            ST_OUT_WAIT:
            begin
                if (!stat.out_busy && !last_i)
                begin
                    i_next = i_reg + CW'(1);
                end
            end
            default:
            begin
                i_next = i_reg;
            end
        endcase
    end

    // strobes
    always_comb
    begin
        ctl          = '0;
        ctl.conv     = conv_reg;
        ctl.out_last = last_i;
        unique case (state_reg)
            ST_CLEAR:       ctl.x_clear = 1'b1;
            ST_SWEEP_START: ctl.maxd_clear = 1'b1;
            ST_ROW_START:   ctl.acc_clear = 1'b1;
            ST_RES_ROW:     ctl.acc_clear = 1'b1;
            ST_ROW_ISSUE:   ctl.mac_issue = 1'b1;
            ST_RES_ISSUE:
            begin
                ctl.mac_issue = 1'b1;
                ctl.mac_all   = 1'b1;
            end
            ST_ROW_NUM:     ctl.num_load = 1'b1;
            ST_DIV_START:   ctl.div_start = 1'b1;
            ST_ROW_WB:      ctl.row_wb = 1'b1;
            ST_SWEEP_CHK:   ctl.bank_flip = 1'b1;
            ST_RES_START:   ctl.res_clear = 1'b1;
            ST_RES_SUB:     ctl.res_sub = 1'b1;
            ST_RES_MAG:     ctl.res_mag = 1'b1;
            ST_RES_SQ:      ctl.res_sq = 1'b1;
            ST_RES_ADD:     ctl.res_add = 1'b1;
            ST_SQRT_START:  ctl.sqrt_start = 1'b1;
            ST_OUT_LD:      ctl.out_load = 1'b1;
            default:        ctl.conv = conv_reg;
        endcase
    end

    assign i_idx      = i_reg[IW-1:0];
    assign j_idx      = j_reg[IW-1:0];
    assign sweeps     = sweeps_reg;
    assign item_stall = state_reg != ST_IDLE;

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.div_start |-> !stat.diag_zero)
        else $error("divide started on a zero diagonal");

    a_check_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP_CHK) |-> !stat.chk_busy)
        else $error("sweep closed before change check drained");

    a_solve_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && solve_go) |=> item_stall)
        else $error("solve accepted without stalling input");

endmodule

`default_nettype wire

// ===== hw/rtl/jacobi_linear_solver_unit.sv =====
`default_nettype none

// Channel   Handshake                  Payload
// item      item_valid / item_stall    cmd, row, col, value
// result    result_valid / result_stall index, solution, iterations,
//                                      converged, residual, last
// config    cfg_we (no wait)           cfg_index, cfg_data
//
// Load transactions (matrix, rhs) are taken one per cycle while idle.
// A solve holds item_stall high until the last result is taken: it clears x,
// then runs its sweeps (each row runs n multiply-accumulate steps, a pipeline
// drain and the 64-step serial divider; a row with a zero diagonal skips the
// divider), then computes the residual and the serial square root and hands
// out one result per row, each held while result_stall is high.
// Reset clears control state and loads register defaults; matrix and rhs
// storage is not cleared and needs no clearing pass.
module jacobi_linear_solver_unit #(
    parameter int MAX_SIZE  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    // item channel
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         cmd,
    input  logic [3:0]         row,
    input  logic [3:0]         col,
    input  logic signed [31:0] value,
    // result channel
    output logic               result_valid,
    input  logic               result_stall,
    output logic [3:0]         index,
    output logic signed [31:0] solution,
    output logic [15:0]        iterations,
    output logic               converged,
    output logic [31:0]        residual,
    output logic               last,
    // configuration
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data
);

    import jls_pkg::*;

    localparam int IW = $clog2(MAX_SIZE);

    logic [4:0]    size_reg;
    logic [30:0]   tol_reg;
    logic [15:0]   maxit_reg;
    logic          accept;
    ctl_t          ctl;
    stat_t         stat;
    logic [IW-1:0] i_idx, j_idx;
    logic [15:0]   sweeps;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= 5'd16;
            tol_reg   <= 31'd66;
            maxit_reg <= 16'd100;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SIZE:  size_reg  <= cfg_data[4:0];
                CFG_TOL:   tol_reg   <= cfg_data;
                CFG_MAXIT: maxit_reg <= cfg_data[15:0];
                default:   size_reg  <= size_reg;
            endcase
        end
    end

    // item transaction taken this cycle
    assign accept = item_valid && !item_stall;

    jls_ctrl #(.MAX_SIZE(MAX_SIZE)) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .item_cmd       (cmd),
        .size_in_use    (size_reg),
        .max_iterations (maxit_reg),
        .stat           (stat),
        .ctl            (ctl),
        .i_idx          (i_idx),
        .j_idx          (j_idx),
        .sweeps         (sweeps),
        .item_stall     (item_stall)
    );

    jls_datapath #(.MAX_SIZE(MAX_SIZE), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .i_idx        (i_idx),
        .j_idx        (j_idx),
        .load_en      (accept),
        .cmd          (cmd),
        .row          (row),
        .col          (col),
        .value        (value),
        .tolerance    (tol_reg),
        .sweeps       (sweeps),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .index        (index),
        .solution     (solution),
        .iterations   (iterations),
        .converged    (converged),
        .residual     (residual),
        .last         (last)
    );

endmodule

`default_nettype wire
